// ===== sv/thc_pkg.sv =====
// Shared types, constants and helpers for the temperature/humidity compensation block.
// No dependencies; the design modules refer to this package by scoped names.
package thc_pkg;

    // Humidity status codes
    typedef enum logic [1:0] {
        HUM_OK          = 2'd0,
        HUM_RAW_INVALID = 2'd1,
        HUM_CAL_ZERO    = 2'd2
    } hum_status_t;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_TEMP_COEF_ONE      = 3'd0;
    localparam logic [2:0] REG_TEMP_COEF_TWO      = 3'd1;
    localparam logic [2:0] REG_TEMP_COEF_THREE    = 3'd2;
    localparam logic [2:0] REG_HUM_COEF_ONE       = 3'd3;
    localparam logic [2:0] REG_HUM_COEF_TWO       = 3'd4;
    localparam logic [2:0] REG_HUM_COEF_THREE     = 3'd5;
    localparam logic [2:0] REG_HUM_COEF_FOUR_FIVE = 3'd6;
    localparam logic [2:0] REG_HUM_COEF_SIX       = 3'd7;

    localparam int unsigned ADDR_W = 5;

    // Arithmetic constants
    localparam logic [31:0] CENTI_ROUND = 32'd128;
    localparam logic [31:0] FINE_OFFSET = 32'd76800;
    localparam logic [31:0] X_ROUND     = 32'd16384;
    localparam logic [31:0] Y_BIAS      = 32'd32768;
    localparam logic [31:0] Y_OFFSET    = 32'd2097152;
    localparam logic [31:0] Y_ROUND     = 32'd8192;
    localparam logic [31:0] HUM_MAX     = 32'd419430400;
    localparam logic [15:0] RAW_ONES    = 16'hFFFF;
    localparam logic [15:0] RAW_MID     = 16'h8000;

    // Calibration coefficients as held in the register file
    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [7:0]  h1;
        logic signed [15:0] h2;
        logic        [7:0]  h3;
        logic signed [11:0] h4;
        logic signed [11:0] h5;
        logic signed [7:0]  h6;
    } coef_t;

    // Word handed from the temperature pipe to the humidity pipe
    typedef struct packed {
        logic [31:0] fine;
        logic [15:0] hum_sample;
        hum_status_t status;
    } temp_word_t;

    // Arithmetic shift right of a 32-bit two's-complement pattern
    function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
        logic signed [31:0] s;
        s = $signed(v);
        return $unsigned(s >>> n);
    endfunction

endpackage

// ===== sv/thc_stream_if.sv =====
// Valid/ready channel interfaces for the sample and result words.
// Depends on nothing; payload fields follow the block's field widths.
interface thc_sample_if;
    logic        valid;
    logic        ready;
    logic [19:0] temp_sample;
    logic [15:0] hum_sample;

    modport source (output valid, output temp_sample, output hum_sample, input ready);
    modport sink   (input valid, input temp_sample, input hum_sample, output ready);
endinterface

interface thc_result_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] temperature_centi;
    logic signed [23:0] fine_temperature;
    logic        [16:0] humidity_q10;
    logic        [1:0]  humidity_status;

    modport source (output valid, output temperature_centi, output fine_temperature,
                    output humidity_q10, output humidity_status, input ready);
    modport sink   (input valid, input temperature_centi, input fine_temperature,
                    input humidity_q10, input humidity_status, output ready);
endinterface

// ===== sv/temp_humidity_compensation.sv =====
// Top level of the temperature/humidity compensation block.
// Depends on thc_pkg, thc_stream_if, thc_regs, thc_temp and thc_hum.
//
// Takes one raw temperature/humidity word per cycle and returns one result word
// for each, in order, through ten register stages: three of the temperature
// multiply chain followed by seven of the humidity chain, the last being the
// output register. Throughput is one word per clock; the whole pipe holds while
// a finished result waits and the output is not ready. Coefficients are written
// over the APB-style port at byte address 4*index and must only change while the
// pipe is empty.
module temp_humidity_compensation (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [thc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    thc_sample_if.sink                  sample,
    thc_result_if.source                result
);
    thc_pkg::coef_t      coef;
    thc_pkg::temp_word_t temp_word;
    logic                temp_valid;
    logic                adv;

    // Advance the pipe unless the output word is stalled
    assign adv          = !result.valid || result.ready;
    assign sample.ready = adv;

    thc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    thc_temp u_temp (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (sample.valid),
        .temp_sample  (sample.temp_sample),
        .hum_sample   (sample.hum_sample),
        .coef         (coef),
        .out_valid    (temp_valid),
        .out_word     (temp_word)
    );

    thc_hum u_hum (
        .clk               (clk),
        .rst_n             (rst_n),
        .adv               (adv),
        .in_valid          (temp_valid),
        .in_word           (temp_word),
        .coef              (coef),
        .out_valid         (result.valid),
        .temperature_centi (result.temperature_centi),
        .fine_temperature  (result.fine_temperature),
        .humidity_q10      (result.humidity_q10),
        .humidity_status   (result.humidity_status)
    );

endmodule

// ===== sv/thc_regs.sv =====
// APB-style register file holding the calibration coefficients.
// Depends on thc_pkg (coef_t, register indexes, ADDR_W).
module thc_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [thc_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output thc_pkg::coef_t               coef
);
    logic [15:0] t1_reg, t2_reg, t3_reg, h2_reg;
    logic [7:0]  h1_reg, h3_reg, h6_reg;
    logic [23:0] h45_reg;
    logic        wr_en;
    logic [2:0]  index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = paddr[4:2];

    // Write the addressed register, dropping bits above its width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg  <= '0;
            t2_reg  <= '0;
            t3_reg  <= '0;
            h1_reg  <= '0;
            h2_reg  <= '0;
            h3_reg  <= '0;
            h45_reg <= '0;
            h6_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (index)
                thc_pkg::REG_TEMP_COEF_ONE:      t1_reg  <= pwdata[15:0];
                thc_pkg::REG_TEMP_COEF_TWO:      t2_reg  <= pwdata[15:0];
                thc_pkg::REG_TEMP_COEF_THREE:    t3_reg  <= pwdata[15:0];
                thc_pkg::REG_HUM_COEF_ONE:       h1_reg  <= pwdata[7:0];
                thc_pkg::REG_HUM_COEF_TWO:       h2_reg  <= pwdata[15:0];
                thc_pkg::REG_HUM_COEF_THREE:     h3_reg  <= pwdata[7:0];
                thc_pkg::REG_HUM_COEF_FOUR_FIVE: h45_reg <= pwdata[23:0];
                thc_pkg::REG_HUM_COEF_SIX:       h6_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (index)
            thc_pkg::REG_TEMP_COEF_ONE:      prdata = {16'b0, t1_reg};
            thc_pkg::REG_TEMP_COEF_TWO:      prdata = {16'b0, t2_reg};
            thc_pkg::REG_TEMP_COEF_THREE:    prdata = {16'b0, t3_reg};
            thc_pkg::REG_HUM_COEF_ONE:       prdata = {24'b0, h1_reg};
            thc_pkg::REG_HUM_COEF_TWO:       prdata = {16'b0, h2_reg};
            thc_pkg::REG_HUM_COEF_THREE:     prdata = {24'b0, h3_reg};
            thc_pkg::REG_HUM_COEF_FOUR_FIVE: prdata = {8'b0, h45_reg};
            thc_pkg::REG_HUM_COEF_SIX:       prdata = {24'b0, h6_reg};
            default:                         prdata = '0;
        endcase
    end

    // Present the coefficients, signed where coef_t declares them signed
    always_comb
    begin
        coef.t1 = t1_reg;
        coef.t2 = $signed(t2_reg);
        coef.t3 = $signed(t3_reg);
        coef.h1 = h1_reg;
        coef.h2 = $signed(h2_reg);
        coef.h3 = h3_reg;
        coef.h4 = $signed(h45_reg[11:0]);
        coef.h5 = $signed(h45_reg[23:12]);
        coef.h6 = $signed(h6_reg);
    end

endmodule

// ===== sv/thc_temp.sv =====
// Three-stage temperature pipe: fine temperature and the humidity status code.
// Depends on thc_pkg (coef_t, temp_word_t, asr, status codes).
module thc_temp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [19:0]         temp_sample,
    input  logic [15:0]         hum_sample,
    input  thc_pkg::coef_t      coef,
    output logic                out_valid,
    output thc_pkg::temp_word_t out_word
);
    logic [2:0]            vld_reg;
    logic [31:0]           d1, d2, t2x, t3x;
    logic [31:0]           pa_reg, pb_reg, a_reg, q_reg, fine_reg;
    logic [15:0]           hum1_reg, hum2_reg, hum3_reg;
    thc_pkg::hum_status_t  status_next;
    thc_pkg::hum_status_t  st1_reg, st2_reg, st3_reg;

    assign t2x = {{16{coef.t2[15]}}, coef.t2};
    assign t3x = {{16{coef.t3[15]}}, coef.t3};
    assign d1  = {15'b0, temp_sample[19:3]} - {15'b0, coef.t1, 1'b0};
    assign d2  = {16'b0, temp_sample[19:4]} - {16'b0, coef.t1};

    // Classify the humidity sample; a bad raw value takes precedence
    always_comb
    begin
        if (hum_sample == 16'd0 || hum_sample == thc_pkg::RAW_ONES
            || hum_sample == thc_pkg::RAW_MID)
            status_next = thc_pkg::HUM_RAW_INVALID;
        else if (coef.h1 == 8'd0 && coef.h2 == 16'sd0)
            status_next = thc_pkg::HUM_CAL_ZERO;
        else
            status_next = thc_pkg::HUM_OK;
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[1:0], in_valid};
    end

    // Stage payloads: products, then scaled terms, then the sum
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg   <= d1 * t2x;
            pb_reg   <= d2 * d2;
            hum1_reg <= hum_sample;
            st1_reg  <= status_next;

            a_reg    <= thc_pkg::asr(pa_reg, 11);
            q_reg    <= thc_pkg::asr(pb_reg, 12) * t3x;
            hum2_reg <= hum1_reg;
            st2_reg  <= st1_reg;

            fine_reg <= a_reg + thc_pkg::asr(q_reg, 14);
            hum3_reg <= hum2_reg;
            st3_reg  <= st2_reg;
        end
    end

    assign out_valid           = vld_reg[2];
    assign out_word.fine       = fine_reg;
    assign out_word.hum_sample = hum3_reg;
    assign out_word.status     = st3_reg;

endmodule

// ===== sv/thc_hum.sv =====
// Seven-stage humidity pipe with the centi-degree scaling and the output register.
// Depends on thc_pkg (coef_t, temp_word_t, asr, constants, status codes).
module thc_hum (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  thc_pkg::temp_word_t in_word,
    input  thc_pkg::coef_t      coef,
    output logic                out_valid,
    output logic signed [17:0]  temperature_centi,
    output logic signed [23:0]  fine_temperature,
    output logic [16:0]         humidity_q10,
    output logic [1:0]          humidity_status
);
    localparam int unsigned NSTAGE = 7;

    logic [NSTAGE-1:0]     vld_reg;
    logic [31:0]           h1x, h2x, h3x, h5x, h6x, v0, v_fin;
    logic [31:0]           cm_reg, m1_reg, m2_reg, m3_reg;
    logic [31:0]           x2_reg, y1_reg, x3_reg, y2_reg;
    logic [31:0]           p4_reg, p5_reg, sq_reg, p6_reg, t6_reg;
    logic [17:0]           centi2_reg, centi3_reg, centi4_reg, centi5_reg, centi6_reg;
    logic [23:0]           fine1_reg, fine2_reg, fine3_reg, fine4_reg, fine5_reg, fine6_reg;
    logic [15:0]           rh1_reg;
    logic [16:0]           hum_next;
    thc_pkg::hum_status_t  st1_reg, st2_reg, st3_reg, st4_reg, st5_reg, st6_reg;
    logic [17:0]           centi_out_reg;
    logic [23:0]           fine_out_reg;
    logic [16:0]           hum_out_reg;
    thc_pkg::hum_status_t  st_out_reg;

    assign h1x = {24'b0, coef.h1};
    assign h2x = {{16{coef.h2[15]}}, coef.h2};
    assign h3x = {24'b0, coef.h3};
    assign h5x = {{20{coef.h5[11]}}, coef.h5};
    assign h6x = {{24{coef.h6[7]}}, coef.h6};
    assign v0  = in_word.fine - thc_pkg::FINE_OFFSET;

    // Subtract the curvature term, clamp, and scale to 1/1024 %RH; zero unless status is OK
    always_comb
    begin
        v_fin = p6_reg - thc_pkg::asr(t6_reg, 4);
        if (v_fin[31])
            v_fin = '0;
        if (v_fin > thc_pkg::HUM_MAX)
            v_fin = thc_pkg::HUM_MAX;
        hum_next = v_fin[28:12];
        if (st6_reg != thc_pkg::HUM_OK)
            hum_next = '0;
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSTAGE-2:0], in_valid};
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // centi-degree sum and products of the offset fine temperature
            cm_reg    <= {in_word.fine[29:0], 2'b00} + in_word.fine + thc_pkg::CENTI_ROUND;
            m1_reg    <= h5x * v0;
            m2_reg    <= v0 * h6x;
            m3_reg    <= v0 * h3x;
            rh1_reg   <= in_word.hum_sample;
            fine1_reg <= in_word.fine[23:0];
            st1_reg   <= in_word.status;

            // raw term and first humidity factor
            x2_reg     <= thc_pkg::asr({2'b0, rh1_reg, 14'b0} - {coef.h4, 20'b0}
                                       - m1_reg + thc_pkg::X_ROUND, 15);
            y1_reg     <= thc_pkg::asr(m2_reg, 10)
                          * (thc_pkg::asr(m3_reg, 11) + thc_pkg::Y_BIAS);
            centi2_reg <= cm_reg[25:8];
            fine2_reg  <= fine1_reg;
            st2_reg    <= st1_reg;

            // scale by coefficient two
            x3_reg     <= x2_reg;
            y2_reg     <= (thc_pkg::asr(y1_reg, 10) + thc_pkg::Y_OFFSET) * h2x
                          + thc_pkg::Y_ROUND;
            centi3_reg <= centi2_reg;
            fine3_reg  <= fine2_reg;
            st3_reg    <= st2_reg;

            // combine both factors
            p4_reg     <= x3_reg * thc_pkg::asr(y2_reg, 14);
            centi4_reg <= centi3_reg;
            fine4_reg  <= fine3_reg;
            st4_reg    <= st3_reg;

            // square the scaled humidity
            p5_reg     <= p4_reg;
            sq_reg     <= thc_pkg::asr(p4_reg, 15) * thc_pkg::asr(p4_reg, 15);
            centi5_reg <= centi4_reg;
            fine5_reg  <= fine4_reg;
            st5_reg    <= st4_reg;

            // weight by coefficient one
            p6_reg     <= p5_reg;
            t6_reg     <= thc_pkg::asr(sq_reg, 7) * h1x;
            centi6_reg <= centi5_reg;
            fine6_reg  <= fine5_reg;
            st6_reg    <= st5_reg;

            // output register
            centi_out_reg <= centi6_reg;
            fine_out_reg  <= fine6_reg;
            hum_out_reg   <= hum_next;
            st_out_reg    <= st6_reg;
        end
    end

    assign out_valid         = vld_reg[NSTAGE-1];
    assign temperature_centi = $signed(centi_out_reg);
    assign fine_temperature  = $signed(fine_out_reg);
    assign humidity_q10      = hum_out_reg;
    assign humidity_status   = st_out_reg;

endmodule
